// ===== rtl/amtd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// amtd_pkg
// Shared types and constants for the multi-tap detector: field widths,
// configuration register indexes and reset values, fixed-point constants.
// ----------------------------------------------------------------------------
package amtd_pkg;

    localparam int unsigned Z_W      = 16;
    localparam int unsigned BTIME_W  = 32;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned THR_W    = 15;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned IVL_W    = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned TIME_W   = 40;
    localparam int unsigned FRAC_W   = 8;
    localparam int unsigned CNT_W    = 8;

    localparam int unsigned MAX_BATCH = 32;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_BATCH - 1);

    localparam int unsigned SCALE_W = 15;
    localparam logic [SCALE_W-1:0] NINE_TENTHS_Q15 = 15'd29491;

    localparam logic [THR_W-1:0] THRESHOLD_RST = 15'd2560;
    localparam logic [MS_W-1:0]  LATENCY_RST   = 16'd80;
    localparam logic [MS_W-1:0]  TIMEOUT_RST   = 16'd2000;
    localparam logic [IVL_W-1:0] INTERVAL_RST  = 16'd2462;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MIN_REPORT = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_LATENCY   = 2'd1,
        CFG_TIMEOUT   = 2'd2,
        CFG_INTERVAL  = 2'd3
    } t_cfg_idx;

endpackage
`default_nettype wire

// ===== rtl/accel_multi_tap_detector.sv =====
`default_nettype none
// Pipeline: a time stamp stage registers each input beat, then the detector
//   update stage feeds the result register that drives o_out_valid; a
//   stalled result side holds both stages.
// Throughput: one beat per cycle while the result side keeps up; the
//   detector state updates once per beat in the second stage.
// Reset: synchronous, active low; clears detector state, restores register
//   defaults and empties both stages.
// ----------------------------------------------------------------------------
// accel_multi_tap_detector
// Z-axis tap detector: arms on a jump, counts taps inside the latency
// window and reports groups of two or more taps after a quiet timeout.
// ----------------------------------------------------------------------------
module accel_multi_tap_detector (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [amtd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [amtd_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  signed [amtd_pkg::Z_W-1:0]     i_z_accel,
    input  wire  [amtd_pkg::BTIME_W-1:0]        i_batch_time_ms,
    input  wire  [amtd_pkg::IDX_W-1:0]          i_sample_index,
    input  wire                                 i_last_in_batch,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [amtd_pkg::BTIME_W-1:0]        o_tap_time_ms,
    output logic [amtd_pkg::CNT_W-1:0]          o_tap_count
);
    import amtd_pkg::*;

    logic [THR_W-1:0]   r_threshold;
    logic [MS_W-1:0]    r_latency;
    logic [MS_W-1:0]    r_timeout;
    logic [IVL_W-1:0]   r_interval;

    logic               r_a_vld;
    logic signed [Z_W-1:0] r_a_z;
    logic [BTIME_W-1:0] r_a_btime;
    logic [TIME_W-1:0]  r_a_t;
    logic               r_a_last;

    logic signed [Z_W-1:0] r_prev;
    logic               r_primed;
    logic signed [Z_W-1:0] r_base;
    logic               r_armed;
    logic [TIME_W-1:0]  r_rise;
    logic [CNT_W-1:0]   r_taps;
    logic [BTIME_W-1:0] r_last_tap;

    logic               r_o_vld;
    logic [BTIME_W-1:0] r_o_time;
    logic [CNT_W-1:0]   r_o_cnt;

    logic                  a_fire;
    logic                  b_fire;
    logic [IDX_W-1:0]      idx_sat;
    logic [IDX_W+IVL_W-1:0] idx_off;
    logic [TIME_W-1:0]     t_in;

    logic signed [Z_W-1:0] prev_eff;
    logic signed [Z_W:0]   d_prev;
    logic [Z_W-1:0]        mag_prev;
    logic [Z_W+SCALE_W:0]  scaled;
    logic [Z_W-1:0]        part;
    logic signed [Z_W:0]   base_wide;
    logic signed [Z_W:0]   d_base;
    logic [Z_W-1:0]        mag_base;
    logic [TIME_W-1:0]     elapsed;
    logic [TIME_W-1:0]     window;
    logic [BTIME_W-1:0]    quiet;
    logic                  emit_chk;

    logic signed [Z_W-1:0] n_base;
    logic               n_armed;
    logic [TIME_W-1:0]  n_rise;
    logic [CNT_W-1:0]   n_taps;
    logic [BTIME_W-1:0] n_last_tap;

    assign b_fire     = r_a_vld && (!r_o_vld || i_out_ready);
    assign o_in_ready = !r_a_vld || b_fire;
    assign a_fire     = i_in_valid && o_in_ready;

    assign o_out_valid   = r_o_vld;
    assign o_tap_time_ms = r_o_time;
    assign o_tap_count   = r_o_cnt;

    always_comb begin
        idx_sat = (i_sample_index > IDX_MAX) ? IDX_MAX : i_sample_index;
        idx_off = IDX_W'(idx_sat) * r_interval;
        t_in    = {i_batch_time_ms, FRAC_W'(0)} + TIME_W'(idx_off);
    end

    always_comb begin
        prev_eff   = r_primed ? r_prev : r_a_z;
        d_prev     = (Z_W+1)'(r_a_z) - (Z_W+1)'(prev_eff);
        mag_prev   = d_prev[Z_W] ? Z_W'(-d_prev) : Z_W'(d_prev);
        scaled     = (Z_W+SCALE_W+1)'(mag_prev) * (Z_W+SCALE_W+1)'(NINE_TENTHS_Q15)
                   + (Z_W+SCALE_W+1)'(1 << (SCALE_W - 1));
        part       = scaled[Z_W+SCALE_W-1:SCALE_W];
        base_wide  = d_prev[Z_W] ? (Z_W+1)'(prev_eff) - (Z_W+1)'($signed({1'b0, part}))
                                 : (Z_W+1)'(prev_eff) + (Z_W+1)'($signed({1'b0, part}));
        d_base     = (Z_W+1)'(r_a_z) - (Z_W+1)'(r_base);
        mag_base   = d_base[Z_W] ? Z_W'(-d_base) : Z_W'(d_base);
        elapsed    = r_a_t - r_rise;
        window     = TIME_W'({r_latency, FRAC_W'(0)});

        n_base     = r_base;
        n_armed    = r_armed;
        n_rise     = r_rise;
        n_taps     = r_taps;
        n_last_tap = r_last_tap;

        if (r_armed) begin
            if (elapsed < window) begin
                if (mag_base > Z_W'(r_threshold)) begin
                    n_last_tap = r_a_btime;
                    n_taps     = (r_taps == CNT_MAX) ? r_taps : r_taps + 1'b1;
                    n_armed    = 1'b0;
                end
            end else begin
                n_armed = 1'b0;
            end
        end else if (mag_prev > Z_W'(r_threshold)) begin
            n_armed = 1'b1;
            n_rise  = r_a_t;
            n_base  = Z_W'(base_wide);
        end

        quiet    = r_a_btime - n_last_tap;
        emit_chk = r_a_last && (n_last_tap != '0) && (quiet > BTIME_W'(r_timeout));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_latency   <= LATENCY_RST;
            r_timeout   <= TIMEOUT_RST;
            r_interval  <= INTERVAL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                CFG_LATENCY:   r_latency   <= i_cfg_data[MS_W-1:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[MS_W-1:0];
                CFG_INTERVAL:  r_interval  <= i_cfg_data[IVL_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_a_vld <= i_in_valid;
        end
        if (a_fire) begin
            r_a_z     <= i_z_accel;
            r_a_btime <= i_batch_time_ms;
            r_a_t     <= t_in;
            r_a_last  <= i_last_in_batch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_primed   <= 1'b0;
            r_base     <= '0;
            r_armed    <= 1'b0;
            r_rise     <= '0;
            r_taps     <= '0;
            r_last_tap <= '0;
            r_o_vld    <= 1'b0;
        end else begin
            if (b_fire && emit_chk && (n_taps >= CNT_MIN_REPORT)) begin
                r_o_vld <= 1'b1;
            end else if (r_o_vld && i_out_ready) begin
                r_o_vld <= 1'b0;
            end
            if (b_fire) begin
                r_prev   <= r_a_z;
                r_primed <= 1'b1;
                r_base   <= n_base;
                r_armed  <= n_armed;
                r_rise   <= n_rise;
                if (emit_chk) begin
                    r_taps     <= '0;
                    r_last_tap <= '0;
                end else begin
                    r_taps     <= n_taps;
                    r_last_tap <= n_last_tap;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire && emit_chk) begin
            r_o_time <= r_a_btime;
            r_o_cnt  <= n_taps;
        end
    end

`ifndef SYNTH
    a_count_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> r_o_cnt >= CNT_MIN_REPORT)
        else $error("reported tap count below two");

    a_clear_on_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire && emit_chk |=> r_taps == '0 && r_last_tap == '0)
        else $error("tap counters not cleared after report check");

    a_taps_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !b_fire |=> $stable(r_taps) && $stable(r_armed))
        else $error("detector state moved without a beat");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_o_vld && !r_a_vld && !r_armed && !r_primed)
        else $error("state not cleared by reset");
`endif

endmodule
`default_nettype wire

// ===== test/tap_check_pkg.sv =====
// ----------------------------------------------------------------------------
// tap_check_pkg
// Scoreboard for the multi-tap detector: mirrors the detector state and
// register values, predicts the tap groups reported from the sample beats and
// compares the groups delivered by the block against them in order.
// ----------------------------------------------------------------------------
package tap_check_pkg;

    import amtd_pkg::*;

    localparam int MAX_PRINTS = 40;

    typedef struct {
        logic [BTIME_W-1:0] when;
        logic [CNT_W-1:0]   count;
    } tap_group_t;

    class tap_scoreboard;

        logic [THR_W-1:0]       threshold;
        logic [MS_W-1:0]        latency_ms;
        logic [MS_W-1:0]        timeout_ms;
        logic [IVL_W-1:0]       interval_q8;

        logic signed [Z_W-1:0] prev_z;
        logic signed [Z_W-1:0] baseline_z;
        logic                   primed;
        logic                   armed;
        logic [TIME_W-1:0]      rise_time;
        logic [CNT_W-1:0]       taps_seen;
        logic [BTIME_W-1:0]     last_tap;

        tap_group_t             groups_due[$];
        int                     errors;
        int                     samples;
        int                     groups;
        int                     full_groups;

        function new();
            threshold   = THRESHOLD_RST;
            latency_ms  = LATENCY_RST;
            timeout_ms  = TIMEOUT_RST;
            interval_q8 = INTERVAL_RST;
            prev_z      = '0;
            baseline_z  = '0;
            primed      = 1'b0;
            armed       = 1'b0;
            rise_time   = '0;
            taps_seen   = '0;
            last_tap    = '0;
            errors      = 0;
            samples     = 0;
            groups      = 0;
            full_groups = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: threshold   = data[THR_W-1:0];
                CFG_LATENCY:   latency_ms  = data[MS_W-1:0];
                CFG_TIMEOUT:   timeout_ms  = data[MS_W-1:0];
                CFG_INTERVAL:  interval_q8 = data[IVL_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [Z_W:0] distance(logic signed [Z_W-1:0] a, logic signed [Z_W-1:0] b);
            logic signed [Z_W:0] d;
            d = {a[Z_W-1], a} - {b[Z_W-1], b};
            return d[Z_W] ? -d : d;
        endfunction

        function void note_sample(logic signed [Z_W-1:0] z, logic [BTIME_W-1:0] btime,
                                  logic [IDX_W-1:0] idx, logic is_last);
            logic [TIME_W-1:0]  stamp;
            logic [TIME_W-1:0]  elapsed;
            logic [Z_W:0]       mag;
            logic [31:0]        part;
            logic [BTIME_W-1:0] quiet;
            tap_group_t         g;
            samples++;
            stamp = {btime, {FRAC_W{1'b0}}} + TIME_W'(idx) * TIME_W'(interval_q8);
            if (!primed) begin
                prev_z = z;
                primed = 1'b1;
            end
            if (armed) begin
                elapsed = stamp - rise_time;
                if (elapsed < {latency_ms, {FRAC_W{1'b0}}}) begin
                    if (distance(z, baseline_z) > threshold) begin
                        last_tap = btime;
                        if (taps_seen != CNT_MAX) taps_seen = taps_seen + 1'b1;
                        armed = 1'b0;
                    end
                end else begin
                    armed = 1'b0;
                end
            end else begin
                mag = distance(z, prev_z);
                if (mag > threshold) begin
                    part = (32'(mag) * 32'(NINE_TENTHS_Q15) + 32'd16384) >> 15;
                    armed = 1'b1;
                    rise_time = stamp;
                    baseline_z = (z >= prev_z) ? prev_z + part[Z_W-1:0]
                                               : prev_z - part[Z_W-1:0];
                end
            end
            prev_z = z;
            quiet = btime - last_tap;
            if (is_last && last_tap != '0 && quiet > BTIME_W'(timeout_ms)) begin
                if (taps_seen >= CNT_MIN_REPORT) begin
                    g.when  = btime;
                    g.count = taps_seen;
                    groups_due.push_back(g);
                end
                taps_seen = '0;
                last_tap  = '0;
            end
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTS) $display("ERROR: tap group %0d: %s", groups, what);
            errors++;
        endtask

        task check_result(logic [BTIME_W-1:0] when, logic [CNT_W-1:0] count);
            tap_group_t g;
            if (groups_due.size() == 0) begin
                report_mismatch($sformatf("unexpected beat at %0d ms with count %0d",
                                          when, count));
                return;
            end
            g = groups_due.pop_front();
            groups++;
            if (count == CNT_MAX) full_groups++;
            if (when !== g.when)
                report_mismatch($sformatf("tap_time_ms %0d, want %0d", when, g.when));
            if (count !== g.count)
                report_mismatch($sformatf("tap_count %0d, want %0d", count, g.count));
        endtask

        function int pending();
            return groups_due.size();
        endfunction

    endclass

endpackage

// ===== test/tb_accel_multi_tap_detector.sv =====
// ----------------------------------------------------------------------------
// tb_accel_multi_tap_detector
// Drives z samples in batches through the tap detector under random source
// gaps and sink stalls, over several register settings, and checks every
// reported tap group against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_accel_multi_tap_detector;

    timeunit 1ns;
    timeprecision 1ps;

    import amtd_pkg::*;
    import tap_check_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT_NS    = 2_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [Z_W-1:0] z_accel = '0;
    logic [BTIME_W-1:0]    batch_time = '0;
    logic [IDX_W-1:0]      sample_index = '0;
    logic                  last_in_batch = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [BTIME_W-1:0]    tap_time;
    logic [CNT_W-1:0]      tap_count;

    tap_scoreboard         sb;
    bit                    calm = 1'b0;
    bit                    hold_req = 1'b0;
    int                    settings_run = 1;

    accel_multi_tap_detector i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_z_accel       (z_accel),
        .i_batch_time_ms (batch_time),
        .i_sample_index  (sample_index),
        .i_last_in_batch (last_in_batch),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_tap_time_ms   (tap_time),
        .o_tap_count     (tap_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic send_sample(input logic signed [Z_W-1:0] z, input logic [BTIME_W-1:0] bt,
                               input logic [IDX_W-1:0] idx, input logic is_last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        z_accel       <= z;
        batch_time    <= bt;
        sample_index  <= idx;
        last_in_batch <= is_last;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(z, bt, idx, is_last);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(input logic [THR_W-1:0] thr, input logic [MS_W-1:0] lat,
                                input logic [MS_W-1:0] tmo, input logic [IVL_W-1:0] ivl);
        set_reg(CFG_THRESHOLD, {1'($urandom_range(0, 1)), thr});
        set_reg(CFG_LATENCY, lat);
        set_reg(CFG_TIMEOUT, tmo);
        set_reg(CFG_INTERVAL, ivl);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    function automatic logic signed [Z_W-1:0] to_z(int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return Z_W'(v);
    endfunction

    task automatic run_phase(input logic [THR_W-1:0] thr, input logic [MS_W-1:0] lat,
                             input logic [MS_W-1:0] tmo, input logic [IVL_W-1:0] ivl,
                             input int n_items, input int step_max, input int long_pct,
                             input int noise_pct, input int jitter, input int calm_pct,
                             input logic [BTIME_W-1:0] start, input bit squeeze);
        int                    sent;
        int                    len;
        int                    roll;
        int                    amp;
        int                    zi;
        int                    level;
        bit                    spiked;
        logic [BTIME_W-1:0]    bt;
        logic signed [Z_W-1:0] z;
        logic signed [Z_W-1:0] last_z;
        program_regs(thr, lat, tmo, ivl);
        if (squeeze) hold_req = 1'b1;
        bt = start;
        level = int'($urandom_range(0, 16000)) - 8000;
        last_z = to_z(level);
        spiked = 1'b0;
        sent = 0;
        while (sent < n_items) begin
            calm = ($urandom_range(0, 99) < calm_pct);
            len = ($urandom_range(0, 9) == 0) ? MAX_BATCH : $urandom_range(1, 8);
            roll = $urandom_range(0, 99);
            if (roll < long_pct)
                bt += BTIME_W'(tmo) + $urandom_range(1, 300);
            else if (long_pct > 0 && roll < long_pct + 5)
                bt += BTIME_W'(tmo);
            else
                bt += $urandom_range(0, step_max);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 99) < noise_pct) begin
                    z = Z_W'($urandom);
                    send_sample(z, $urandom, IDX_W'($urandom), 1'($urandom));
                end else begin
                    if (spiked || $urandom_range(0, 99) >= 35) begin
                        zi = level + int'($urandom_range(0, 2 * jitter)) - jitter;
                        spiked = 1'b0;
                    end else begin
                        amp = int'(thr) + int'($urandom_range(1, thr / 4 + 64));
                        zi = $urandom_range(0, 1) ? level + amp : level - amp;
                        if (zi > 32767) zi = level - amp;
                        if (zi < -32768) zi = level + amp;
                        spiked = 1'b1;
                    end
                    z = to_z(zi);
                    send_sample(z, bt, IDX_W'(i), i == len - 1);
                end
                last_z = z;
                sent++;
            end
        end
        // hold z steady across two quiet batches to flush the pending group
        bt += BTIME_W'(tmo) + 1 + $urandom_range(0, 50);
        send_sample(last_z, bt, '0, 1'b1);
        bt += BTIME_W'(tmo) + 1 + $urandom_range(0, 50);
        send_sample(last_z, bt, '0, 1'b1);
        settle();
    endtask

    initial begin : result_sink
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = calm ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(tap_time, tap_count);
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("accel_multi_tap_detector: mismatch");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_sample(16'sh7fff, 32'd0, 5'd0, 1'b0);
        send_sample(16'sh8000, 32'd0, 5'd1, 1'b0);
        send_sample(16'sh7fff, 32'd0, 5'd2, 1'b1);
        send_sample(16'sd0, 32'd100, 5'd0, 1'b0);
        send_sample(16'sd10000, 32'd100, 5'd1, 1'b0);
        send_sample(16'sd10000, 32'd100, 5'd2, 1'b1);
        send_sample(-16'sd20000, 32'd150, 5'd0, 1'b0);
        send_sample(-16'sd20000, 32'd150, 5'd31, 1'b1);
        send_sample(-16'sd20000, 32'd2100, 5'd0, 1'b1);
        send_sample(-16'sd20000, 32'd2101, 5'd0, 1'b1);
        send_sample(16'sd0, 32'd3000, 5'd0, 1'b0);
        send_sample(-16'sd20000, 32'd3000, 5'd1, 1'b0);
        send_sample(-16'sd20000, 32'd6000, 5'd0, 1'b1);
        send_sample(-16'sd17440, 32'd7000, 5'd0, 1'b0);
        send_sample(-16'sd14879, 32'd7000, 5'd1, 1'b0);
        send_sample(-16'sd14879, 32'd7000, 5'd2, 1'b0);
        send_sample(-16'sd30000, 32'd7000, 5'd3, 1'b0);
        send_sample(16'sd0, 32'd7010, 5'd0, 1'b0);
        send_sample(16'sd30000, 32'd7005, 5'd0, 1'b0);
        send_sample(-16'sd30000, 32'd7012, 5'd0, 1'b0);
        send_sample(16'sd30000, 32'd7012, 5'd1, 1'b1);
        send_sample(16'sd30000, 32'hFFFF_FFFF, 5'd31, 1'b1);
        settle();

        run_phase(15'd2560, 16'd80, 16'd2000, 16'd2462, 250, 400, 20, 10, 300, 20,
                  $urandom, 1'b0);
        run_phase(15'd0, 16'hFFFF, 16'hFFFF, 16'd1, 650, 30, 0, 0, 200, 100,
                  $urandom, 1'b0);
        run_phase(15'h7FFF, 16'd0, 16'd0, 16'hFFFF, 150, 50, 20, 10, 2000, 20,
                  $urandom, 1'b0);
        run_phase(15'd1000, 16'hFFFF, 16'd0, 16'hFFFF, 250, 3, 30, 5, 100, 20,
                  32'hFFFF_FF00, 1'b1);
        run_phase(15'd300, 16'd40, 16'd500, 16'd1000, 250, 150, 20, 10, 40, 20,
                  $urandom, 1'b0);
        run_phase(15'd2560, 16'd80, 16'd2000, 16'd2462, 150, 400, 20, 30, 300, 40,
                  $urandom, 1'b0);

        $display("covered %0d sample beats over %0d register settings", sb.samples,
                 settings_run);
        $display("checked %0d reported tap groups, %0d of them at the saturated count",
                 sb.groups, sb.full_groups);
        if (sb.errors == 0) begin
            $display("accel_multi_tap_detector: match");
        end else begin
            $display("accel_multi_tap_detector: mismatch");
        end
        $finish;
    end

endmodule
